// ===== rtl/dv_audio_sample_locate_decode_defines.svh =====
// Assertion macros for the DV audio sample locate and decode block
`ifndef DV_AUDIO_SAMPLE_LOCATE_DECODE_DEFINES_SVH
`define DV_AUDIO_SAMPLE_LOCATE_DECODE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DVASL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define DVASL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define DVASL_ASSERT_IMP(lbl, ante, cons, msg)
`define DVASL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/dvasl_pkg.sv =====
// Shared types and constants for the DV audio sample locate and decode block
`timescale 1ns / 1ps
`default_nettype none
package dvasl_pkg;

	localparam logic REG_PAL_MODE   = 1'b0;
	localparam logic REG_QUANT_MODE = 1'b1;

	localparam logic [2:0] QUANT_LINEAR16 = 3'd0;
	localparam logic [2:0] QUANT_NONLIN12 = 3'd1;

	localparam logic [3:0] SEQ_NTSC = 4'd5;
	localparam logic [3:0] SEQ_PAL  = 4'd6;
	localparam logic [4:0] SYNC_NTSC = 5'd15;
	localparam logic [4:0] SYNC_PAL  = 5'd18;

	// floor(n/3) = (n*683) >> 11 for n < 2048
	localparam logic [9:0] DIV3_MUL = 10'd683;
	localparam int         DIV3_SHIFT = 11;
	// floor(q/P) = (q*M) >> 14 for q < 683
	localparam logic [10:0] DIVP_MUL_NTSC = 11'd1093;
	localparam logic [10:0] DIVP_MUL_PAL  = 11'd911;
	localparam int          DIVP_SHIFT = 14;

	localparam logic [10:0] LIMIT16_NTSC = 11'd1620;
	localparam logic [10:0] LIMIT16_PAL  = 11'd1944;
	localparam logic [10:0] LIMIT12_NTSC = 11'd1080;
	localparam logic [10:0] LIMIT12_PAL  = 11'd1296;

	localparam logic [7:0] BLOCK_BASE  = 8'd6;
	localparam logic [6:0] OFFSET_BASE = 7'd5;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	typedef struct packed {
		logic [3:0] lseq;
		logic [3:0] rseq;
		logic [7:0] blk;
		logic [6:0] off;
		logic       in_frame;
	} loc_t;

endpackage
`default_nettype wire

// ===== rtl/dvasl_ifs.sv =====
// Valid/ready channel interfaces for input items and result items
`timescale 1ns / 1ps
`default_nettype none
interface dvasl_in_if;
	logic        valid;
	logic        ready;
	logic [10:0] sample_index;
	logic [7:0]  first_byte;
	logic [7:0]  second_byte;
	logic [7:0]  third_byte;
	logic [7:0]  right_high;
	logic [7:0]  right_low;

	modport source (
		output valid, sample_index, first_byte, second_byte, third_byte,
			right_high, right_low,
		input  ready
	);
	modport sink (
		input  valid, sample_index, first_byte, second_byte, third_byte,
			right_high, right_low,
		output ready
	);
endinterface

interface dvasl_out_if;
	logic               valid;
	logic               ready;
	logic [3:0]         left_sequence;
	logic [3:0]         right_sequence;
	logic [7:0]         block_index;
	logic [6:0]         byte_offset;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               sample_good;

	modport source (
		output valid, left_sequence, right_sequence, block_index, byte_offset,
			left_sample, right_sample, sample_good,
		input  ready
	);
	modport sink (
		input  valid, left_sequence, right_sequence, block_index, byte_offset,
			left_sample, right_sample, sample_good,
		output ready
	);
endinterface
`default_nettype wire

// ===== rtl/dvasl_chan_lane.sv =====
// One channel decode lane: 16-bit join or 12-bit nonlinear expand, error detect
`timescale 1ns / 1ps
`default_nettype none
module dvasl_chan_lane (
	input  wire                  clk,
	input  dvasl_pkg::stage_en_t en,
	input  wire                  twelve,
	input  wire                  linear,
	input  wire  [11:0]          code12,
	input  wire  [15:0]          word16,
	output logic [15:0]          samp_s1,
	output logic                 err_s1
);
	import dvasl_pkg::*;

	function automatic logic [15:0] expand12(input logic [11:0] c);
		logic [17:0] cx;
		logic [17:0] v;
		cx = {6'd0, c};
		case (c[11:8])
			4'he, 4'hf: v = {2'b00, 4'hf, c};
			4'hd:       v = (((cx + 18'd257)  << 1) | 18'h0e000) - 18'd1;
			4'hc:       v = (((cx + 18'd513)  << 2) | 18'h0c000) - 18'd1;
			4'hb:       v = (((cx + 18'd769)  << 3) | 18'h08000) - 18'd1;
			4'ha:       v = (((cx + 18'd1025) << 4) | 18'h08000) - 18'd1;
			4'h9:       v = (((cx + 18'd1281) << 5) | 18'h08000) - 18'd1;
			4'h8:       v = (((cx + 18'd1537) << 6) | 18'h08000) - 18'd1;
			4'h7:       v = (cx - 18'd1536) << 6;
			4'h6:       v = (cx - 18'd1280) << 5;
			4'h5:       v = (cx - 18'd1024) << 4;
			4'h4:       v = (cx - 18'd768)  << 3;
			4'h3:       v = (cx - 18'd512)  << 2;
			4'h2:       v = (cx - 18'd256)  << 1;
			default:    v = cx;
		endcase
		return v[15:0];
	endfunction

	logic [15:0] samp;
	logic        err;

	always_comb begin
		samp = 16'd0;
		err  = 1'b0;
		if (twelve) begin
			err  = (code12 == 12'h800);
			samp = err ? 16'd0 : expand12(code12);
		end else if (linear) begin
			err  = (word16 == 16'h8000);
			samp = err ? 16'd0 : word16;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			samp_s1 <= samp;
			err_s1  <= err;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/dvasl_locate.sv =====
// Shuffle locator: sequence, DIF block and byte offset over three stages
`timescale 1ns / 1ps
`default_nettype none
module dvasl_locate (
	input  wire                  clk,
	input  dvasl_pkg::stage_en_t en,
	input  wire                  pal_mode,
	input  wire                  twelve,
	input  wire  [10:0]          n,
	output logic                 in_frame_s2,
	output dvasl_pkg::loc_t      loc_s3
);
	import dvasl_pkg::*;

	logic [3:0]  t;
	logic [4:0]  p;
	logic [10:0] recip;
	logic [10:0] limit;

	assign t     = pal_mode ? SEQ_PAL : SEQ_NTSC;
	assign p     = pal_mode ? SYNC_PAL : SYNC_NTSC;
	assign recip = pal_mode ? DIVP_MUL_PAL : DIVP_MUL_NTSC;
	assign limit = twelve ? (pal_mode ? LIMIT12_PAL : LIMIT12_NTSC)
		: (pal_mode ? LIMIT16_PAL : LIMIT16_NTSC);

	// stage 1: n / 3
	logic [20:0] prod3;
	logic [10:0] n_s1;
	logic [9:0]  q3_s1;
	logic        in_frame_s1;

	assign prod3 = 21'(n) * 21'(DIV3_MUL);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			n_s1        <= n;
			q3_s1       <= prod3[DIV3_SHIFT +: 10];
			in_frame_s1 <= (n < limit);
		end
	end

	// stage 2: n % 3 and (n/3) / P
	logic [11:0] r3_full;
	logic [20:0] prodp;
	logic [1:0]  r3_s2;
	logic [9:0]  q3_s2;
	logic [5:0]  qp_s2;

	assign r3_full = 12'(n_s1) - 12'(q3_s1) * 12'd3;
	assign prodp   = 21'(q3_s1) * 21'(recip);

	always_ff @(posedge clk) begin
		if (en.s2) begin
			r3_s2       <= r3_full[1:0];
			q3_s2       <= q3_s1;
			qp_s2       <= prodp[DIVP_SHIFT +: 6];
			in_frame_s2 <= in_frame_s1;
		end
	end

	// stage 3: remainders, sequence, block and offset
	logic [9:0] rp_full;
	logic [4:0] rp;
	logic [5:0] bsum;
	logic [1:0] bq;
	logic [4:0] rt;
	logic [3:0] ssum;
	logic [3:0] lseq;
	loc_t       loc;

	always_comb begin
		rp_full = q3_s2 - 10'(qp_s2) * 10'(p);
		rp      = rp_full[4:0];
		bsum    = 6'(rp) * 6'd3 + 6'(r3_s2);
		if (bsum >= 6'({p, 1'b0}))
			bq = 2'd2;
		else if (bsum >= 6'(p))
			bq = 2'd1;
		else
			bq = 2'd0;
		if (rp >= 5'({t, 1'b0}))
			rt = rp - 5'({t, 1'b0});
		else if (rp >= 5'(t))
			rt = rp - 5'(t);
		else
			rt = rp;
		ssum = 4'(rt) + 4'({r3_s2, 1'b0});
		lseq = (ssum >= t) ? ssum - t : ssum;
		loc = '0;
		if (in_frame_s2) begin
			loc.lseq     = lseq;
			loc.rseq     = twelve ? lseq : lseq + t;
			loc.blk      = BLOCK_BASE + {4'(r3_s2) * 4'd3 + 4'(bq), 4'd0};
			loc.off      = OFFSET_BASE + (twelve ? 7'(qp_s2) * 7'd3 : {qp_s2, 1'b0});
			loc.in_frame = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3)
			loc_s3 <= loc;
	end
endmodule
`default_nettype wire

// ===== rtl/dv_audio_sample_locate_decode.sv =====
// Top level: config registers, pipeline control, two decode lanes and merge
//
//  channel  | dir | payload                                        | handshake
//  item     | in  | sample_index, first/second/third_byte, right_* | valid/ready
//  result   | out | sequences, block_index, byte_offset, samples   | valid/ready
//  cfg      | in  | cfg_index, cfg_wr_data                         | cfg_wr_en
//
// Items pass stage registers s1 and s2 into the s3 result register; one item per cycle while result is not stalled.
// Left and right lanes decode in parallel with the locator; the last stage merges.
// Each stage advances when empty or when the stage after it advances; result is
// the output register, so a stalled result leaves upstream bubbles fillable.
// Reset clears valid flags and config registers (NTSC, 16-bit linear).
`timescale 1ns / 1ps
`default_nettype none
`include "dv_audio_sample_locate_decode_defines.svh"
module dv_audio_sample_locate_decode (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_wr_en,
	input  wire         cfg_index,
	input  wire  [2:0]  cfg_wr_data,
	dvasl_in_if.sink    item,
	dvasl_out_if.source result
);
	import dvasl_pkg::*;

	logic       pal_mode_q;
	logic [2:0] quant_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_mode_q   <= 1'b0;
			quant_mode_q <= QUANT_LINEAR16;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_PAL_MODE:   pal_mode_q   <= cfg_wr_data[0];
				REG_QUANT_MODE: quant_mode_q <= cfg_wr_data;
				default:        ;
			endcase
		end
	end

	logic twelve;
	logic linear;
	assign twelve = (quant_mode_q == QUANT_NONLIN12);
	assign linear = (quant_mode_q == QUANT_LINEAR16);

	logic      vld_s1, vld_s2, vld_s3;
	stage_en_t en;

	assign en.s3      = !vld_s3 || result.ready;
	assign en.s2      = !vld_s2 || en.s3;
	assign en.s1      = !vld_s1 || en.s2;
	assign item.ready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en.s1)
				vld_s1 <= item.valid;
			if (en.s2)
				vld_s2 <= vld_s1;
			if (en.s3)
				vld_s3 <= vld_s2;
		end
	end

	logic       in_frame_s2;
	loc_t       loc_s3;

	dvasl_locate u_locate (
		.clk         (clk),
		.en          (en),
		.pal_mode    (pal_mode_q),
		.twelve      (twelve),
		.n           (item.sample_index),
		.in_frame_s2 (in_frame_s2),
		.loc_s3      (loc_s3)
	);

	logic [15:0] lsamp_s1, rsamp_s1;
	logic        lerr_s1, rerr_s1;

	dvasl_chan_lane u_lane_left (
		.clk     (clk),
		.en      (en),
		.twelve  (twelve),
		.linear  (linear),
		.code12  ({item.first_byte, item.third_byte[7:4]}),
		.word16  ({item.first_byte, item.second_byte}),
		.samp_s1 (lsamp_s1),
		.err_s1  (lerr_s1)
	);

	dvasl_chan_lane u_lane_right (
		.clk     (clk),
		.en      (en),
		.twelve  (twelve),
		.linear  (linear),
		.code12  ({item.second_byte, item.third_byte[3:0]}),
		.word16  ({item.right_high, item.right_low}),
		.samp_s1 (rsamp_s1),
		.err_s1  (rerr_s1)
	);

	logic [15:0] lsamp_s2, rsamp_s2;
	logic        err_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			lsamp_s2 <= lsamp_s1;
			rsamp_s2 <= rsamp_s1;
			err_s2   <= lerr_s1 || rerr_s1;
		end
	end

	logic [15:0] lsamp_s3, rsamp_s3;
	logic        good_s3;
	logic        use_s2;

	assign use_s2 = in_frame_s2 && !err_s2;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			lsamp_s3 <= use_s2 ? lsamp_s2 : 16'd0;
			rsamp_s3 <= use_s2 ? rsamp_s2 : 16'd0;
			good_s3  <= use_s2;
		end
	end

	assign result.valid          = vld_s3;
	assign result.left_sequence  = loc_s3.lseq;
	assign result.right_sequence = loc_s3.rseq;
	assign result.block_index    = loc_s3.blk;
	assign result.byte_offset    = loc_s3.off;
	assign result.left_sample    = lsamp_s3;
	assign result.right_sample   = rsamp_s3;
	assign result.sample_good    = good_s3;

	`DVASL_ASSERT_IMP(a_bad_zero, result.valid && !result.sample_good, result.left_sample == 16'd0 && result.right_sample == 16'd0, "bad pair carries nonzero samples")
	`DVASL_ASSERT_IMP(a_seq12, result.valid && twelve, result.right_sequence == result.left_sequence, "12-bit sequences differ")
	`DVASL_ASSERT_IMP(a_good_loc, result.valid && result.sample_good, result.left_sequence < 4'd12 && result.block_index >= BLOCK_BASE && result.byte_offset >= OFFSET_BASE, "good result with bad location")
	`DVASL_ASSERT_IMP(a_good_frame, result.valid && result.sample_good, loc_s3.in_frame, "good result outside frame")
	`DVASL_ASSERT_NXT(a_fill, item.valid && item.ready, vld_s1, "accepted item lost at stage 1")
endmodule
`default_nettype wire

// ===== tb/sv/dv_audio_sample_locate_decode_test.sv =====
// Self-checking bench: DV audio sample location and decode against an in-bench predictor
`timescale 1ns / 1ps

import dvasl_pkg::*;

localparam logic [11:0] ERR_CODE12 = 12'h800;
localparam logic [15:0] ERR_WORD16 = 16'h8000;

typedef struct packed {
	logic [10:0] idx;
	logic [7:0]  b0;
	logic [7:0]  b1;
	logic [7:0]  b2;
	logic [7:0]  rh;
	logic [7:0]  rl;
} dv_item_t;

typedef struct packed {
	logic [3:0]         lseq;
	logic [3:0]         rseq;
	logic [7:0]         blk;
	logic [6:0]         off;
	logic signed [15:0] ls;
	logic signed [15:0] rs;
	logic               good;
} dv_result_t;

class decoded_pair_check;
	dv_result_t  expected_pairs[$];
	int unsigned accepted;
	int unsigned checked;
	int unsigned failures;

	function new();
		accepted = 0;
		checked = 0;
		failures = 0;
	endfunction

	static function int unsigned frame_size(bit pal, logic [2:0] quant);
		return ((quant == QUANT_NONLIN12) ? 24 : 36) * 3 * (pal ? 18 : 15);
	endfunction

	// piecewise 12-bit to 16-bit expansion
	static function logic [15:0] widen_code(logic [11:0] c);
		int unsigned v;
		v = c;
		if (c >= 12'he00)      v = v | 'hf000;
		else if (c >= 12'hd00) v = (((v + 257) << 1) | 'he000) - 1;
		else if (c >= 12'hc00) v = (((v + 513) << 2) | 'hc000) - 1;
		else if (c >= 12'hb00) v = (((v + 769) << 3) | 'h8000) - 1;
		else if (c >= 12'ha00) v = (((v + 1025) << 4) | 'h8000) - 1;
		else if (c >= 12'h900) v = (((v + 1281) << 5) | 'h8000) - 1;
		else if (c >= 12'h800) v = (((v + 1537) << 6) | 'h8000) - 1;
		else if (c >= 12'h700) v = (v - 1536) << 6;
		else if (c >= 12'h600) v = (v - 1280) << 5;
		else if (c >= 12'h500) v = (v - 1024) << 4;
		else if (c >= 12'h400) v = (v - 768) << 3;
		else if (c >= 12'h300) v = (v - 512) << 2;
		else if (c >= 12'h200) v = (v - 256) << 1;
		return v[15:0];
	endfunction

	static function dv_result_t locate_and_decode(dv_item_t it, bit pal, logic [2:0] quant);
		dv_result_t  r;
		int unsigned n;
		int unsigned t;
		int unsigned p;
		logic [11:0] c1;
		logic [11:0] c2;
		logic [15:0] lw;
		logic [15:0] rw;
		r = '0;
		n = it.idx;
		t = pal ? 6 : 5;
		p = pal ? 18 : 15;
		if (n < frame_size(pal, quant)) begin
			r.lseq = 4'((n / 3 + 2 * (n % 3)) % t);
			r.blk = 8'(6 + 16 * (3 * (n % 3) + (n % (3 * p)) / p));
			r.good = 1'b1;
			if (quant == QUANT_NONLIN12) begin
				c1 = {it.b0, it.b2[7:4]};
				c2 = {it.b1, it.b2[3:0]};
				r.rseq = r.lseq;
				r.off = 7'(5 + 3 * (n / (3 * p)));
				if (c1 == ERR_CODE12 || c2 == ERR_CODE12) begin
					r.good = 1'b0;
				end else begin
					r.ls = widen_code(c1);
					r.rs = widen_code(c2);
				end
			end else begin
				r.rseq = 4'(r.lseq + t);
				r.off = 7'(5 + 2 * (n / (3 * p)));
				if (quant == QUANT_LINEAR16) begin
					lw = {it.b0, it.b1};
					rw = {it.rh, it.rl};
					if (lw == ERR_WORD16 || rw == ERR_WORD16) begin
						r.good = 1'b0;
					end else begin
						r.ls = lw;
						r.rs = rw;
					end
				end
			end
		end
		return r;
	endfunction

	function void note_item(dv_item_t it, bit pal, logic [2:0] quant);
		expected_pairs.push_back(locate_and_decode(it, pal, quant));
		accepted++;
	endfunction

	function void field_eq(string fname, int want, int got);
		if (want != got) begin
			failures++;
			$error("%s: expected %0d, actual %0d", fname, want, got);
		end
	endfunction

	function void check_pair(dv_result_t got);
		dv_result_t want;
		checked++;
		if (expected_pairs.size() == 0) begin
			failures++;
			$error("result transfer with no pending expectation");
			return;
		end
		want = expected_pairs.pop_front();
		field_eq("left_sequence", want.lseq, got.lseq);
		field_eq("right_sequence", want.rseq, got.rseq);
		field_eq("block_index", want.blk, got.blk);
		field_eq("byte_offset", want.off, got.off);
		field_eq("left_sample", $signed(want.ls), $signed(got.ls));
		field_eq("right_sample", $signed(want.rs), $signed(got.rs));
		field_eq("sample_good", want.good, got.good);
	endfunction

	function int pending();
		return expected_pairs.size();
	endfunction
endclass

module dv_audio_sample_locate_decode_test;
	localparam int PHASES = 12;
	localparam int ITEMS_PER_PHASE = 160;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic       cfg_index = REG_PAL_MODE;
	logic [2:0] cfg_wr_data = 3'd0;

	bit          pal_cfg = 1'b0;
	logic [2:0]  quant_cfg = QUANT_LINEAR16;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;

	bit         phase_pal[PHASES] = '{0, 0, 1, 1, 1, 0, 1, 0, 0, 1, 1, 0};
	logic [2:0] phase_quant[PHASES] = '{3'd0, 3'd1, 3'd7, 3'd0, 3'd1, 3'd0,
		3'd3, 3'd1, 3'd2, 3'd1, 3'd0, 3'd6};

	decoded_pair_check board;

	dvasl_in_if  in_ch ();
	dvasl_out_if out_ch ();

	dv_audio_sample_locate_decode u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.item        (in_ch),
		.result      (out_ch)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (hold_asks != hold_served) begin
			hold_served <= hold_served + 1;
			hold_left <= 400;
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				board.note_item('{in_ch.sample_index, in_ch.first_byte, in_ch.second_byte,
					in_ch.third_byte, in_ch.right_high, in_ch.right_low}, pal_cfg, quant_cfg);
			if (out_ch.valid && out_ch.ready)
				board.check_pair('{out_ch.left_sequence, out_ch.right_sequence,
					out_ch.block_index, out_ch.byte_offset, out_ch.left_sample,
					out_ch.right_sample, out_ch.sample_good});
		end
	end

	task automatic program_regs(bit pal, logic [2:0] quant);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_PAL_MODE;
		cfg_wr_data <= {2'($urandom_range(0, 3)), pal};
		@(posedge clk);
		cfg_index <= REG_QUANT_MODE;
		cfg_wr_data <= quant;
		pal_cfg <= pal;
		quant_cfg <= quant;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_item(dv_item_t it);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_index <= it.idx;
		in_ch.first_byte <= it.b0;
		in_ch.second_byte <= it.b1;
		in_ch.third_byte <= it.b2;
		in_ch.right_high <= it.rh;
		in_ch.right_low <= it.rl;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	function automatic dv_item_t random_item(bit pal, logic [2:0] quant);
		dv_item_t    it;
		int unsigned lim;
		int unsigned sel;
		lim = board.frame_size(pal, quant);
		sel = $urandom_range(0, 15);
		it.idx = ($urandom_range(0, 4) == 0) ? 11'($urandom_range(0, 2047))
			: 11'($urandom_range(0, lim - 1));
		it.b0 = 8'($urandom);
		it.b1 = 8'($urandom);
		it.b2 = 8'($urandom);
		it.rh = 8'($urandom);
		it.rl = 8'($urandom);
		if (quant == QUANT_NONLIN12) begin
			if (sel == 0) begin
				it.b0 = ERR_CODE12[11:4];
				it.b2[7:4] = ERR_CODE12[3:0];
			end else if (sel == 1) begin
				it.b1 = ERR_CODE12[11:4];
				it.b2[3:0] = ERR_CODE12[3:0];
			end
		end else if (sel == 0) begin
			{it.b0, it.b1} = ERR_WORD16;
		end else if (sel == 1) begin
			{it.rh, it.rl} = ERR_WORD16;
		end
		return it;
	endfunction

	task automatic run_directed(bit pal, logic [2:0] quant);
		dv_item_t    list[$];
		int unsigned lim;
		lim = board.frame_size(pal, quant);
		if (quant == QUANT_NONLIN12) begin
			list.push_back('{11'd0, ERR_CODE12[11:4], 8'h12, {ERR_CODE12[3:0], 4'h5},
				8'h00, 8'h00});
			list.push_back('{11'd1, 8'h12, ERR_CODE12[11:4], {4'h5, ERR_CODE12[3:0]},
				8'h00, 8'h00});
			list.push_back('{11'd2, ERR_CODE12[11:4], ERR_CODE12[11:4],
				{ERR_CODE12[3:0], ERR_CODE12[3:0]}, 8'hff, 8'hff});
			list.push_back('{11'd3, 8'h7f, 8'h80, 8'hf1, 8'hff, 8'hff});
			list.push_back('{11'd4, 8'he0, 8'hdf, 8'h0f, 8'h00, 8'h00});
			list.push_back('{11'd44, 8'hff, 8'h00, 8'hf0, 8'h00, 8'h00});
			list.push_back('{11'd45, 8'h1f, 8'h20, 8'hf0, 8'h00, 8'h00});
			list.push_back('{11'(lim - 1), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
			list.push_back('{11'(lim), 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc});
			list.push_back('{11'h7ff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
		end else begin
			list.push_back('{11'd0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
			list.push_back('{11'd1, 8'h7f, 8'hff, 8'h00, 8'h7f, 8'hff});
			list.push_back('{11'd2, 8'hff, 8'hff, 8'hff, 8'h80, 8'h01});
			list.push_back('{11'd3, ERR_WORD16[15:8], ERR_WORD16[7:0], 8'h5a, 8'h12, 8'h34});
			list.push_back('{11'd44, 8'h12, 8'h34, 8'h00, ERR_WORD16[15:8], ERR_WORD16[7:0]});
			list.push_back('{11'd45, ERR_WORD16[15:8], ERR_WORD16[7:0], 8'h00,
				ERR_WORD16[15:8], ERR_WORD16[7:0]});
			list.push_back('{11'd46, 8'h80, 8'h01, 8'h00, 8'h00, 8'h80});
			list.push_back('{11'(lim - 1), 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
			list.push_back('{11'(lim), ERR_WORD16[15:8], ERR_WORD16[7:0], 8'h11, 8'h22, 8'h33});
			list.push_back('{11'h7ff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
		end
		foreach (list[i])
			send_item(list[i]);
	endtask

	task automatic drain();
		int unsigned guard;
		guard = 0;
		while (board.pending() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (6) @(posedge clk);
	endtask

	initial begin
		board = new();
		in_ch.valid = 1'b0;
		in_ch.sample_index = '0;
		in_ch.first_byte = '0;
		in_ch.second_byte = '0;
		in_ch.third_byte = '0;
		in_ch.right_high = '0;
		in_ch.right_low = '0;
		out_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct <= 77;
				end
				1: begin
					send_idle_pct = 77;
					recv_idle_pct <= 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct <= 0;
				end
			endcase
			program_regs(phase_pal[ph], phase_quant[ph]);
			if (ph < 2)
				run_directed(phase_pal[ph], phase_quant[ph]);
			// long output stall with the input kept busy
			if (ph == 8)
				hold_asks <= hold_asks + 1;
			repeat (ITEMS_PER_PHASE)
				send_item(random_item(phase_pal[ph], phase_quant[ph]));
			in_ch.valid <= 1'b0;
			drain();
		end
		if (board.pending() != 0) begin
			board.failures++;
			$error("%0d expected results never arrived", board.pending());
		end
		$display("run covered %0d input transfers and %0d result transfers", board.accepted,
			board.checked);
		$display("over %0d register settings: NTSC and PAL, linear, nonlinear, unsupported",
			PHASES);
		if (board.failures == 0)
			$display("dv_audio_sample_locate_decode: match");
		else
			$display("dv_audio_sample_locate_decode: mismatch");
		$finish;
	end

	initial begin
		#5000000;
		$display("dv_audio_sample_locate_decode: mismatch");
		$finish;
	end
endmodule
